FILE: rtl/gnot_pkg.sv
// shared constants and types for the gradient noise octave terrain unit
package gnot_pkg;

    localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
    localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
    localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    localparam int CFG_SIDE_W = 7;
    localparam int AREA_W     = 14;

    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_SAMPLE   = 1'b1;

    localparam logic REG_SEED      = 1'b0;
    localparam logic REG_GRID_SIDE = 1'b1;

    typedef logic [15:0] t_q14;

endpackage

FILE: rtl/gnot_ram.sv
// generic simple dual port ram with registered read
module gnot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gradient_noise_octave_terrain_unit.sv
// top level: gradient table generation and octave noise sampling
//
// usage
//   configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   index 0 is the seed, index 1 the grid side. write only while busy is low.
//   commands: a transfer happens when start is high and busy is low.
//   generate (i_command 0) hashes a cell and writes its gradient into the
//   table ram; busy stays high from the hash through the table write.
//   it returns nothing. a cell outside the grid is dropped without going busy.
//   sample (i_command 1) runs each octave through fade, one remainder
//   pass of the restoring divider for the table index, an address step,
//   four corner reads from the single ram read port and lerp plus
//   accumulate. the final scaling by the weight sum uses a reciprocal
//   multiply, and busy stays high until that scaling is done.
//   the result shows on o_noise_sum and o_level for one cycle with o_valid,
//   in the first cycle after busy falls.
//   one command is in flight at a time; the receiver cannot stall.
//   reset (synchronous, active low) returns to idle with seed 0 and side 64;
//   the gradient table is not cleared.
module gradient_noise_octave_terrain_unit
    import gnot_pkg::*;
#(
    parameter int MAX_SIDE        = 64,
    parameter int OCTAVES         = 6,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [5:0]         i_cell_col,
    input  logic [5:0]         i_cell_row,
    input  logic [17:0]        i_pos_x,
    input  logic [17:0]        i_pos_y,
    output logic               o_valid,
    output logic signed [15:0] o_noise_sum,
    output logic signed [4:0]  o_level,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int QUARTER = 1 << SINE_TABLE_BITS;
    localparam int PW      = SINE_TABLE_BITS + 2;
    localparam int XW      = 18 + OCTAVES - 1;
    localparam int X0W     = XW - 16;
    localparam int VW      = X0W + 8;
    localparam int DW      = VW + AREA_W;
    localparam int TW      = OCTAVES + 40;
    localparam int AW      = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int OCW     = $clog2(OCTAVES + 1);
    localparam int DEN     = (1 << OCTAVES) - 1;
    localparam int MW      = 30;
    localparam logic [31:0] RECIP = 32'(((64'd1 << 36) + 64'(DEN - 1)) / 64'(DEN));

    typedef logic [15:0] t_sine [0:QUARTER];

    typedef enum logic [4:0] {
        S_IDLE, S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6,
        S_OCT, S_F1, S_F2, S_DIV, S_ADDR, S_RD, S_L1, S_L2, S_ACC,
        S_NS, S_LV, S_OUT
    } t_state;

    function automatic t_sine gen_sine();
        t_sine      rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int k = 0; k <= QUARTER; k++) begin
            x  = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
            rom[k] = 16'((((x * t) >> 30) + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam t_sine SINE = gen_sine();

    function automatic t_q14 wave(input logic [PW-1:0] ph);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [SINE_TABLE_BITS:0]   ri;
        logic [15:0]                v;
        idx = ph[SINE_TABLE_BITS-1:0];
        ri  = (SINE_TABLE_BITS + 1)'(QUARTER) - {1'b0, idx};
        v   = ph[SINE_TABLE_BITS] ? SINE[ri] : SINE[idx];
        return ph[SINE_TABLE_BITS+1] ? 16'(-v) : v;
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[31:0];
    endfunction

    function automatic logic [31:0] rotl16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    function automatic logic [AREA_W-1:0] wrap_add(input logic [AREA_W-1:0] a,
                                                   input logic [AREA_W-1:0] b,
                                                   input logic [AREA_W-1:0] m);
        logic [AREA_W:0] c;
        c = {1'b0, a} + {1'b0, b};
        if (c >= {1'b0, m}) begin
            c = c - {1'b0, m};
        end
        return c[AREA_W-1:0];
    endfunction

    t_state                    r_state;
    logic                      r_valid;
    logic [31:0]               r_seed;
    logic [CFG_SIDE_W-1:0]     r_grid_side;
    logic [AREA_W-1:0]         r_area;
    logic [5:0]                r_col;
    logic [5:0]                r_row;
    logic [XW-1:0]             r_px;
    logic [XW-1:0]             r_py;
    logic [OCW-1:0]            r_oct;
    logic signed [TW-1:0]      r_total;
    logic [31:0]               r_ha;
    logic [31:0]               r_hb;
    logic [PW-1:0]             r_phase;
    logic [AW-1:0]             r_waddr;
    t_q14                      r_sin;
    t_q14                      r_cos;
    logic [VW-1:0]             r_v;
    logic [31:0]               r_sx2;
    logic [31:0]               r_sy2;
    logic [15:0]               r_sx3;
    logic [15:0]               r_sy3;
    logic [19:0]               r_xpoly;
    logic [19:0]               r_ypoly;
    logic [16:0]               r_fx;
    logic [16:0]               r_fy;
    logic [VW-1:0]             r_rem;
    logic [DW-1:0]             r_dsh;
    logic [4:0]                r_cnt;
    logic [MW-1:0]             r_mq;
    logic [AREA_W-1:0]         r_c00;
    logic [AREA_W-1:0]         r_c10;
    logic [AREA_W-1:0]         r_c01;
    logic [2:0]                r_k;
    logic signed [33:0]        r_g [0:3];
    logic signed [35:0]        r_l0;
    logic signed [35:0]        r_l1;
    logic signed [35:0]        r_ov;
    logic signed [15:0]        r_noise;
    logic signed [4:0]         r_level;

    logic [CFG_SIDE_W-1:0]     w_side;
    logic [15:0]               w_sx;
    logic [15:0]               w_sy;
    logic [AREA_W-1:0]         w_c11;
    logic [AW-1:0]             w_raddr;
    logic [31:0]               w_rdata;
    logic [1:0]                w_kk;
    logic signed [15:0]        w_gs;
    logic signed [15:0]        w_gc;
    logic signed [16:0]        w_dx;
    logic signed [16:0]        w_dy;
    logic signed [33:0]        w_dot;
    logic signed [17:0]        w_fxs;
    logic signed [17:0]        w_fys;
    logic signed [34:0]        w_d0;
    logic signed [34:0]        w_d1;
    logic signed [52:0]        w_p0;
    logic signed [52:0]        w_p1;
    logic signed [36:0]        w_dl;
    logic signed [54:0]        w_p2;
    logic [TW-1:0]             w_mag;
    logic                      w_neg;
    logic [TW+1:0]             w_ns_num;
    logic [TW+5:0]             w_lv_num;
    logic [MW-1:0]             w_ns_m;
    logic [MW-1:0]             w_lv_m;
    logic [MW+31:0]            w_prod;
    logic [MW-1:0]             w_q;
    logic [OCW-1:0]            w_shamt;
    logic [39:0]               w_poly_x;
    logic [39:0]               w_poly_y;
    logic [3:0]                w_lmag;
    logic                      w_we;

    always_comb begin
        if (r_grid_side == '0) begin
            w_side = CFG_SIDE_W'(1);
        end else if (int'(r_grid_side) > MAX_SIDE) begin
            w_side = CFG_SIDE_W'(MAX_SIDE);
        end else begin
            w_side = r_grid_side;
        end
    end

    assign w_sx  = r_px[15:0];
    assign w_sy  = r_py[15:0];
    assign w_c11 = wrap_add(r_c01, AREA_W'(1), r_area);

    always_comb begin
        case (r_k)
            3'd1:    w_raddr = AW'(r_c10);
            3'd2:    w_raddr = AW'(r_c01);
            3'd3:    w_raddr = AW'(w_c11);
            default: w_raddr = AW'(r_c00);
        endcase
    end

    // read data belongs to the address presented in the previous cycle
    assign w_kk  = 2'(r_k - 3'd1);
    assign w_gs  = w_rdata[15:0];
    assign w_gc  = w_rdata[31:16];
    assign w_dx  = w_kk[0] ? {1'b1, w_sx} : {1'b0, w_sx};
    assign w_dy  = w_kk[1] ? {1'b1, w_sy} : {1'b0, w_sy};
    assign w_dot = 34'(w_gs * w_dx) + 34'(w_gc * w_dy);

    assign w_fxs = {1'b0, r_fx};
    assign w_fys = {1'b0, r_fy};
    assign w_d0  = 35'(r_g[1]) - 35'(r_g[0]);
    assign w_d1  = 35'(r_g[3]) - 35'(r_g[2]);
    assign w_p0  = 53'(w_fxs * w_d0);
    assign w_p1  = 53'(w_fxs * w_d1);
    assign w_dl  = 37'(r_l1) - 37'(r_l0);
    assign w_p2  = 55'(w_fys * w_dl);

    assign w_poly_x = 40'(r_sx2) * 40'd6 + (40'd10 << 32) - ((40'(w_sx) * 40'd15) << 16);
    assign w_poly_y = 40'(r_sy2) * 40'd6 + (40'd10 << 32) - ((40'(w_sy) * 40'd15) << 16);

    assign w_neg   = r_total[TW-1];
    assign w_mag   = w_neg ? TW'(-r_total) : TW'(r_total);
    assign w_shamt = OCW'(OCTAVES - 1) - r_oct;

    // rounded scaling by the weight sum: floor of the biased value, then divide
    assign w_ns_num = {1'b0, w_mag, 1'b0} + ((TW + 2)'(DEN) << 16);
    assign w_lv_num = ((TW + 6)'(w_mag) << 5) - ((TW + 6)'(w_mag) << 1)
                    + ((TW + 6)'(DEN) << 31);
    assign w_ns_m   = MW'(w_ns_num >> 17);
    assign w_lv_m   = MW'(w_lv_num >> 32);
    assign w_prod   = (MW + 32)'(r_mq) * (MW + 32)'(RECIP);
    assign w_q      = MW'(w_prod >> 36);

    assign w_lmag = (w_q > MW'(8)) ? 4'd8 : w_q[3:0];
    assign w_we   = (r_state == S_G6);

    gnot_ram #(
        .WIDTH (32),
        .DEPTH (MAX_SIDE * MAX_SIDE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_waddr),
        .i_wdata ({r_cos, r_sin}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_seed      <= '0;
            r_grid_side <= CFG_SIDE_W'(64);
        end else begin
            r_valid <= 1'b0;
            r_area  <= AREA_W'(w_side * w_side);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SEED:      r_seed      <= i_cfg_data;
                    REG_GRID_SIDE: r_grid_side <= i_cfg_data[CFG_SIDE_W-1:0];
                    default:       ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_col   <= i_cell_col;
                        r_row   <= i_cell_row;
                        r_px    <= XW'(i_pos_x);
                        r_py    <= XW'(i_pos_y);
                        r_oct   <= '0;
                        r_total <= '0;
                        if (i_command == CMD_SAMPLE) begin
                            r_state <= S_OCT;
                        end else if ({1'b0, i_cell_col} < w_side
                                     && {1'b0, i_cell_row} < w_side) begin
                            r_state <= S_G0;
                        end
                    end
                end
                S_G0: begin
                    r_ha    <= mul32(32'(r_col) + r_seed, HASH_MUL_A);
                    r_state <= S_G1;
                end
                S_G1: begin
                    r_hb    <= mul32((32'(r_row) + r_seed) ^ rotl16(r_ha), HASH_MUL_B);
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_ha    <= mul32(r_ha ^ rotl16(r_hb), HASH_MUL_C);
                    r_state <= S_G3;
                end
                S_G3: begin
                    r_phase <= r_ha[31:30-SINE_TABLE_BITS];
                    r_waddr <= AW'(14'(r_row) * 14'(w_side) + 14'(r_col));
                    r_state <= S_G4;
                end
                S_G4: begin
                    r_sin   <= wave(r_phase);
                    r_state <= S_G5;
                end
                S_G5: begin
                    r_cos   <= wave(r_phase + PW'(QUARTER));
                    r_state <= S_G6;
                end
                S_G6: begin
                    r_state <= S_IDLE;
                end
                S_OCT: begin
                    r_v     <= VW'(r_px[XW-1:16]) + VW'(r_py[XW-1:16]) * VW'(w_side);
                    r_sx2   <= 32'(w_sx) * 32'(w_sx);
                    r_sy2   <= 32'(w_sy) * 32'(w_sy);
                    r_state <= S_F1;
                end
                S_F1: begin
                    r_sx3   <= 16'((48'(r_sx2) * 48'(w_sx)) >> 32);
                    r_sy3   <= 16'((48'(r_sy2) * 48'(w_sy)) >> 32);
                    r_xpoly <= w_poly_x[35:16];
                    r_ypoly <= w_poly_y[35:16];
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_fx    <= 17'((36'(r_sx3) * 36'(r_xpoly)) >> 16);
                    r_fy    <= 17'((36'(r_sy3) * 36'(r_ypoly)) >> 16);
                    r_rem   <= r_v;
                    r_dsh   <= DW'(r_area) << (VW - 1);
                    r_cnt   <= 5'(VW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (DW'(r_rem) >= r_dsh) begin
                        r_rem <= r_rem - VW'(r_dsh);
                    end
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_c00   <= AREA_W'(r_rem);
                    r_c10   <= wrap_add(AREA_W'(r_rem), AREA_W'(1), r_area);
                    r_c01   <= wrap_add(AREA_W'(r_rem), AREA_W'(w_side), r_area);
                    r_k     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_k >= 3'd1) begin
                        r_g[w_kk] <= w_dot;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_state <= S_L1;
                    end
                end
                S_L1: begin
                    r_l0    <= 36'(r_g[0]) + 36'(w_p0 >>> 16);
                    r_l1    <= 36'(r_g[2]) + 36'(w_p1 >>> 16);
                    r_state <= S_L2;
                end
                S_L2: begin
                    r_ov    <= r_l0 + 36'(w_p2 >>> 16);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_total <= r_total + (TW'(r_ov) <<< w_shamt);
                    r_oct   <= r_oct + OCW'(1);
                    r_px    <= r_px << 1;
                    r_py    <= r_py << 1;
                    if (r_oct == OCW'(OCTAVES - 1)) begin
                        r_state <= S_NS;
                    end else begin
                        r_state <= S_OCT;
                    end
                end
                S_NS: begin
                    r_mq    <= w_ns_m;
                    r_state <= S_LV;
                end
                S_LV: begin
                    if (w_neg) begin
                        r_noise <= (w_q > MW'(32767)) ? 16'sh8000
                                                      : 16'(-{1'b0, w_q[14:0]});
                    end else begin
                        r_noise <= (w_q > MW'(32767)) ? 16'sh7fff : {1'b0, w_q[14:0]};
                    end
                    r_mq    <= w_lv_m;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_level <= w_neg ? 5'(-{1'b0, w_lmag}) : {1'b0, w_lmag};
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_noise_sum = r_noise;
    assign o_level     = r_level;

    a_sample_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_SAMPLE) |=> busy)
        else $error("sample transfer did not start work");

    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level <= 5'sd8 && o_level >= -5'sd8))
        else $error("level out of range");

    a_level_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_level > 5'sd0) |-> (o_noise_sum >= 16'sd0))
        else $error("level and noise sum disagree in sign");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 5'd0))
        else $error("divider running with zero step count");

endmodule
